FILE: rtl/clbw_pkg.sv
// Package: shared types and byte codes for the character LCD bus writer.
`timescale 1ns / 1ps

package clbw_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] REG_BUS_EIGHT_BIT   = 2'd0;
    localparam logic [1:0] REG_ENABLE_SETUP_US = 2'd1;
    localparam logic [1:0] REG_ENABLE_WIDTH_US = 2'd2;
    localparam logic [1:0] REG_SETTLE_US       = 2'd3;

    localparam logic [15:0] RESET_ENABLE_SETUP_US = 16'd1;
    localparam logic [15:0] RESET_ENABLE_WIDTH_US = 16'd1;
    localparam logic [15:0] RESET_SETTLE_US       = 16'd100;

    localparam logic [7:0] LEAD_C3 = 8'hC3;
    localparam logic [7:0] LEAD_C4 = 8'hC4;
    localparam logic [7:0] LEAD_C5 = 8'hC5;

    localparam logic [7:0] TRAIL_B6 = 8'hB6;
    localparam logic [7:0] TRAIL_96 = 8'h96;
    localparam logic [7:0] TRAIL_BC = 8'hBC;
    localparam logic [7:0] TRAIL_9C = 8'h9C;
    localparam logic [7:0] TRAIL_87 = 8'h87;
    localparam logic [7:0] TRAIL_A7 = 8'hA7;
    localparam logic [7:0] TRAIL_9E = 8'h9E;
    localparam logic [7:0] TRAIL_9F = 8'h9F;
    localparam logic [7:0] TRAIL_B0 = 8'hB0;
    localparam logic [7:0] TRAIL_B1 = 8'hB1;

    localparam logic [7:0] ROM_O_UMLAUT = 8'd239;
    localparam logic [7:0] ROM_U_UMLAUT = 8'd245;
    localparam logic [7:0] GLYPH_C_CEDIL = 8'd0;
    localparam logic [7:0] GLYPH_G_BREVE = 8'd1;
    localparam logic [7:0] GLYPH_S_CEDIL = 8'd2;
    localparam logic [7:0] GLYPH_G_SMALL = 8'd3;
    localparam logic [7:0] GLYPH_I_DOT   = 8'd4;
    localparam logic [7:0] GLYPH_I_DOTLESS = 8'd5;

    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_DATA    = 1'b1;

    localparam logic [1:0] PULSE_SETUP  = 2'd0;
    localparam logic [1:0] PULSE_HIGH   = 2'd1;
    localparam logic [1:0] PULSE_SETTLE = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } clbw_in_t;

    typedef struct packed {
        logic        reg_select;
        logic [7:0]  bus_data;
        logic        enable_level;
        logic [15:0] hold_us;
        logic        last;
    } clbw_out_t;

    typedef struct packed {
        logic        bus_eight_bit;
        logic [15:0] enable_setup_us;
        logic [15:0] enable_width_us;
        logic [15:0] settle_us;
    } clbw_cfg_t;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] code;
    } clbw_entry_t;

endpackage

FILE: rtl/clbw_filter.sv
// Front end: accepts requests, runs the UTF-8 Turkish filter, pushes bytes to send.
`timescale 1ns / 1ps

module clbw_filter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  clbw_pkg::clbw_in_t   in_data,
    input  logic                 queue_full,
    output logic                 in_stall,
    output logic                 push,
    output clbw_pkg::clbw_entry_t push_entry
);
    import clbw_pkg::*;

    logic lead_c4_seen_reg, lead_c4_seen_next;
    logic lead_c5_seen_reg, lead_c5_seen_next;
    logic accept;
    logic send;
    logic [7:0] code;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    always_comb
    begin
        send              = 1'b1;
        code              = in_data.value;
        lead_c4_seen_next = lead_c4_seen_reg;
        lead_c5_seen_next = lead_c5_seen_reg;
        if (in_data.kind == KIND_DATA)
        begin
            unique case (in_data.value)
                LEAD_C3: send = 1'b0;
                LEAD_C4:
                begin
                    send = 1'b0;
                    lead_c4_seen_next = 1'b1;
                end
                LEAD_C5:
                begin
                    send = 1'b0;
                    lead_c5_seen_next = 1'b1;
                end
                TRAIL_B6, TRAIL_96: code = ROM_O_UMLAUT;
                TRAIL_BC, TRAIL_9C: code = ROM_U_UMLAUT;
                TRAIL_87, TRAIL_A7: code = GLYPH_C_CEDIL;
                TRAIL_9E, TRAIL_9F:
                begin
                    priority if (lead_c4_seen_reg)
                    begin
                        lead_c4_seen_next = 1'b0;
                        code = (in_data.value == TRAIL_9E) ? GLYPH_G_BREVE : GLYPH_G_SMALL;
                    end
                    else if (lead_c5_seen_reg)
                    begin
                        lead_c5_seen_next = 1'b0;
                        code = GLYPH_S_CEDIL;
                    end
                    else
                    begin
                        send = 1'b0;
                    end
                end
                TRAIL_B0, TRAIL_B1:
                begin
                    if (lead_c4_seen_reg)
                    begin
                        lead_c4_seen_next = 1'b0;
                        code = (in_data.value == TRAIL_B0) ? GLYPH_I_DOT : GLYPH_I_DOTLESS;
                    end
                    else
                    begin
                        send = 1'b0;
                    end
                end
                default: code = in_data.value;
            endcase
        end
    end

    assign push                  = accept && send;
    assign push_entry.reg_select = in_data.kind;
    assign push_entry.code       = code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_c4_seen_reg <= 1'b0;
            lead_c5_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            lead_c4_seen_reg <= lead_c4_seen_next;
            lead_c5_seen_reg <= lead_c5_seen_next;
        end
    end

endmodule

FILE: rtl/clbw_queue.sv
// Short queue between the filter and the phase sequencer.
`timescale 1ns / 1ps

module clbw_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  clbw_pkg::clbw_entry_t push_entry,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output clbw_pkg::clbw_entry_t head
);
    import clbw_pkg::*;

    clbw_entry_t mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic do_push, do_pop;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/clbw_phase.sv
// Back end: turns each queued byte into enable-pulse bus phases.
`timescale 1ns / 1ps

module clbw_phase (
    input  logic                  clk,
    input  logic                  rst_n,
    input  clbw_pkg::clbw_cfg_t   cfg,
    input  logic                  empty,
    input  clbw_pkg::clbw_entry_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output clbw_pkg::clbw_out_t   out_data
);
    import clbw_pkg::*;

    logic [1:0] pulse_reg, pulse_next;
    logic       nibble_reg, nibble_next;
    logic       out_valid_reg, out_valid_next;
    clbw_out_t  out_data_reg, out_data_next;
    logic       load;
    logic       last_phase;

    assign load       = !empty && (!out_valid_reg || !out_stall);
    assign last_phase = (pulse_reg == PULSE_SETTLE) && (cfg.bus_eight_bit || nibble_reg);
    assign pop        = load && last_phase;

    always_comb
    begin
        pulse_next  = pulse_reg;
        nibble_next = nibble_reg;
        if (load)
        begin
            if (pulse_reg == PULSE_SETTLE)
            begin
                pulse_next  = PULSE_SETUP;
                nibble_next = !last_phase;
            end
            else
            begin
                pulse_next = pulse_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_data_next.reg_select   = head.reg_select;
        out_data_next.last         = last_phase;
        out_data_next.enable_level = (pulse_reg == PULSE_HIGH);
        if (cfg.bus_eight_bit)
            out_data_next.bus_data = head.code;
        else if (nibble_reg)
            out_data_next.bus_data = {4'b0, head.code[3:0]};
        else
            out_data_next.bus_data = {4'b0, head.code[7:4]};
        unique case (pulse_reg)
            PULSE_SETUP: out_data_next.hold_us = cfg.enable_setup_us;
            PULSE_HIGH:  out_data_next.hold_us = cfg.enable_width_us;
            default:     out_data_next.hold_us = cfg.settle_us;
        endcase
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg     <= PULSE_SETUP;
            nibble_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pulse_reg     <= pulse_next;
            nibble_reg    <= nibble_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // pulse counter never reaches the unused code
    assert property (@(posedge clk) disable iff (!rst_n) pulse_reg != 2'd3)
        else $error("pulse counter out of range");

    // the high nibble phase never closes a byte on a 4-bit bus
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && !cfg.bus_eight_bit && !nibble_reg) |-> !pop)
        else $error("pop after high nibble");

    // a request that closes a byte is always a settle phase with enable low
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.last) |-> !out_data_reg.enable_level)
        else $error("last phase with enable high");

    // after a pop the sequencer restarts at the setup phase of the high nibble
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (pulse_reg == PULSE_SETUP && !nibble_reg))
        else $error("sequencer not rewound after pop");

endmodule

FILE: rtl/char_lcd_utf8_bus_writer_top.sv
// Top level of the character LCD bus writer with UTF-8 Turkish filter.
//
//  channel | signals                          | direction | request
//  input   | in_valid, in_stall, in_data      | in        | command or text byte
//  output  | out_valid, out_stall, out_data   | out       | one bus phase
//  config  | cfg_write, cfg_index, cfg_data   | in        | register write
//
// A byte is taken every cycle while the two-entry queue has room; a dropped
// byte leaves no trace on the output. Each sent byte gives 3 phases on an
// 8-bit bus and 6 on a 4-bit bus, one per cycle from the phase sequencer
// while the output is not stalled. Reset clears the lead flags, the queue and
// the output valid flag. Output stall holds the phase register; input stalls
// only when the queue is full.
`timescale 1ns / 1ps

module char_lcd_utf8_bus_writer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  clbw_pkg::clbw_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output clbw_pkg::clbw_out_t out_data,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import clbw_pkg::*;

    clbw_cfg_t   cfg_reg;
    clbw_entry_t push_entry;
    clbw_entry_t head;
    logic        push, pop, full, empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bus_eight_bit   <= 1'b0;
            cfg_reg.enable_setup_us <= RESET_ENABLE_SETUP_US;
            cfg_reg.enable_width_us <= RESET_ENABLE_WIDTH_US;
            cfg_reg.settle_us       <= RESET_SETTLE_US;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BUS_EIGHT_BIT:   cfg_reg.bus_eight_bit   <= cfg_data[0];
                REG_ENABLE_SETUP_US: cfg_reg.enable_setup_us <= cfg_data;
                REG_ENABLE_WIDTH_US: cfg_reg.enable_width_us <= cfg_data;
                default:             cfg_reg.settle_us       <= cfg_data;
            endcase
        end
    end

    clbw_filter u_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .queue_full (full),
        .in_stall   (in_stall),
        .push       (push),
        .push_entry (push_entry)
    );

    clbw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .empty      (empty),
        .head       (head)
    );

    clbw_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: dv/char_lcd_utf8_bus_writer_top_tb.sv
// Testbench for the character LCD bus writer: random and directed bytes checked phase by phase.
`timescale 1ns / 1ps

module char_lcd_utf8_bus_writer_top_tb;
    import clbw_pkg::*;

    localparam int PHASE_COUNT  = 7;
    localparam int BYTES_PER_PH = 38;
    localparam int QUIET_CYCLES = 16;

    localparam logic [7:0] PAIR_LEAD [12] = '{
        LEAD_C3, LEAD_C3, LEAD_C3, LEAD_C3, LEAD_C3, LEAD_C3,
        LEAD_C4, LEAD_C4, LEAD_C4, LEAD_C4, LEAD_C5, LEAD_C5
    };
    localparam logic [7:0] PAIR_TRAIL [12] = '{
        TRAIL_B6, TRAIL_96, TRAIL_BC, TRAIL_9C, TRAIL_87, TRAIL_A7,
        TRAIL_9E, TRAIL_9F, TRAIL_B0, TRAIL_B1, TRAIL_9E, TRAIL_9F
    };

    class lcd_phase_board;
        clbw_cfg_t  cfg;
        bit         c4_flag;
        bit         c5_flag;
        clbw_out_t  phases_due[$];
        int         errors;
        int         sent_bytes;

        function new();
            cfg.bus_eight_bit   = 1'b0;
            cfg.enable_setup_us = RESET_ENABLE_SETUP_US;
            cfg.enable_width_us = RESET_ENABLE_WIDTH_US;
            cfg.settle_us       = RESET_SETTLE_US;
            c4_flag    = 1'b0;
            c5_flag    = 1'b0;
            errors     = 0;
            sent_bytes = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                REG_BUS_EIGHT_BIT:   cfg.bus_eight_bit   = data[0];
                REG_ENABLE_SETUP_US: cfg.enable_setup_us = data;
                REG_ENABLE_WIDTH_US: cfg.enable_width_us = data;
                REG_SETTLE_US:       cfg.settle_us       = data;
                default: ;
            endcase
        endfunction

        // Returns 1 when the text byte goes to the bus, with its display code.
        function bit turkish_map(input logic [7:0] v, output logic [7:0] glyph);
            glyph = v;
            case (v)
                LEAD_C3: return 1'b0;
                LEAD_C4:
                begin
                    c4_flag = 1'b1;
                    return 1'b0;
                end
                LEAD_C5:
                begin
                    c5_flag = 1'b1;
                    return 1'b0;
                end
                TRAIL_B6, TRAIL_96: glyph = ROM_O_UMLAUT;
                TRAIL_BC, TRAIL_9C: glyph = ROM_U_UMLAUT;
                TRAIL_87, TRAIL_A7: glyph = GLYPH_C_CEDIL;
                TRAIL_9E, TRAIL_9F:
                begin
                    if (c4_flag)
                    begin
                        c4_flag = 1'b0;
                        glyph = (v == TRAIL_9E) ? GLYPH_G_BREVE : GLYPH_G_SMALL;
                    end
                    else if (c5_flag)
                    begin
                        c5_flag = 1'b0;
                        glyph = GLYPH_S_CEDIL;
                    end
                    else
                        return 1'b0;
                end
                TRAIL_B0, TRAIL_B1:
                begin
                    if (!c4_flag)
                        return 1'b0;
                    c4_flag = 1'b0;
                    glyph = (v == TRAIL_B0) ? GLYPH_I_DOT : GLYPH_I_DOTLESS;
                end
                default: ;
            endcase
            return 1'b1;
        endfunction

        function void push_pulse(logic rs, logic [7:0] data);
            clbw_out_t ph;
            ph.reg_select   = rs;
            ph.bus_data     = data;
            ph.last         = 1'b0;
            ph.enable_level = 1'b0;
            ph.hold_us      = cfg.enable_setup_us;
            phases_due.push_back(ph);
            ph.enable_level = 1'b1;
            ph.hold_us      = cfg.enable_width_us;
            phases_due.push_back(ph);
            ph.enable_level = 1'b0;
            ph.hold_us      = cfg.settle_us;
            phases_due.push_back(ph);
        endfunction

        function void note_byte(clbw_in_t req);
            logic [7:0] code;
            clbw_out_t  tail;
            code = req.value;
            if (req.kind == KIND_DATA && !turkish_map(req.value, code))
                return;
            sent_bytes++;
            if (cfg.bus_eight_bit)
                push_pulse(req.kind, code);
            else
            begin
                push_pulse(req.kind, {4'h0, code[7:4]});
                push_pulse(req.kind, {4'h0, code[3:0]});
            end
            tail = phases_due.pop_back();
            tail.last = 1'b1;
            phases_due.push_back(tail);
        endfunction

        function void field_error(string name, logic [15:0] want, logic [15:0] got);
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        endfunction

        function void check_phase(clbw_out_t got);
            clbw_out_t want;
            if (phases_due.size() == 0)
            begin
                $display("%0t: phase expected none actual %p", $time, got);
                errors++;
                return;
            end
            want = phases_due.pop_front();
            if (got.reg_select !== want.reg_select)
                field_error("reg_select", 16'(want.reg_select), 16'(got.reg_select));
            if (got.bus_data !== want.bus_data)
                field_error("bus_data", 16'(want.bus_data), 16'(got.bus_data));
            if (got.enable_level !== want.enable_level)
                field_error("enable_level", 16'(want.enable_level), 16'(got.enable_level));
            if (got.hold_us !== want.hold_us)
                field_error("hold_us", want.hold_us, got.hold_us);
            if (got.last !== want.last)
                field_error("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    clbw_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    clbw_out_t   out_data;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    lcd_phase_board sb;
    bit             gaps_on;
    bit             stalls_on;

    char_lcd_utf8_bus_writer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_byte(in_data);
            if (out_valid && !out_stall)
                sb.check_phase(out_data);
        end
    end

    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 299) == 0)
                stalls_on = !stalls_on;
            if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall = 1'b0;
                if (stalls_on && $urandom_range(0, 3) == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 80)
                        stall_left = $urandom_range(1, 2);
                    else if (r < 95)
                        stall_left = $urandom_range(3, 6);
                    else
                        stall_left = $urandom_range(15, 30);
                end
            end
        end
    end

    task automatic idle_gap();
        int r;
        int n;
        n = 0;
        if ($urandom_range(0, 49) == 0)
            gaps_on = !gaps_on;
        if (gaps_on)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                n = 0;
            else if (r < 92)
                n = $urandom_range(1, 3);
            else
                n = $urandom_range(8, 30);
        end
        if (n > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_byte(logic kind, logic [7:0] value);
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = {kind, value};
        do
            @(posedge clk);
        while (in_stall);
        idle_gap();
    endtask

    // Drop valid and hold off until every predicted phase has been seen.
    task automatic wait_quiet(int tail_cycles);
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.phases_due.size() != 0)
            @(posedge clk);
        repeat (tail_cycles) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_setting(int p);
        logic        b;
        logic [15:0] s;
        logic [15:0] w;
        logic [15:0] t;
        logic [15:0] junk;
        junk = 16'($urandom_range(0, 65535));
        case (p)
            1:
            begin
                b = 1'b1; s = 16'd0; w = 16'd0; t = 16'd0;
            end
            2:
            begin
                b = 1'b0; s = 16'hFFFF; w = 16'hFFFF; t = 16'hFFFF;
            end
            4:
            begin
                b = 1'b0; s = 16'd1; w = 16'd0; t = 16'hFFFF;
            end
            5:
            begin
                b = 1'b1; s = 16'hFFFF; w = 16'd1; t = 16'd0;
            end
            default:
            begin
                b = p[0];
                s = 16'($urandom_range(0, 65535));
                w = 16'($urandom_range(0, 65535));
                t = 16'($urandom_range(0, 65535));
            end
        endcase
        write_reg(REG_BUS_EIGHT_BIT, {junk[15:1], b});
        write_reg(REG_ENABLE_SETUP_US, s);
        write_reg(REG_ENABLE_WIDTH_US, w);
        write_reg(REG_SETTLE_US, t);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic send_random_text();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 25)
            send_byte(KIND_DATA, 8'($urandom_range(32, 126)));
        else if (r < 37)
            send_byte(KIND_COMMAND, 8'($urandom_range(0, 255)));
        else if (r < 75)
        begin
            k = $urandom_range(0, 11);
            send_byte(KIND_DATA, PAIR_LEAD[k]);
            if ($urandom_range(0, 4) == 0)
                send_byte(KIND_COMMAND, 8'($urandom_range(0, 255)));
            send_byte(KIND_DATA, PAIR_TRAIL[k]);
        end
        else if (r < 85)
        begin
            // both leads pending, then two trails
            send_byte(KIND_DATA, LEAD_C4);
            send_byte(KIND_DATA, LEAD_C5);
            send_byte(KIND_DATA, $urandom_range(0, 1) ? TRAIL_9E : TRAIL_9F);
            send_byte(KIND_DATA, PAIR_TRAIL[$urandom_range(6, 11)]);
        end
        else if (r < 93)
            send_byte(KIND_DATA, PAIR_TRAIL[$urandom_range(6, 11)]);
        else
            send_byte(KIND_DATA, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 59) == 0)
            wait_quiet(0);
    endtask

    initial
    begin
        clbw_in_t directed [25];
        int       target;
        directed = '{
            {KIND_COMMAND, 8'h00}, {KIND_COMMAND, 8'hFF}, {KIND_DATA, 8'h00},
            {KIND_DATA, 8'hFF},    {KIND_DATA, LEAD_C3},  {KIND_DATA, TRAIL_B6},
            {KIND_DATA, TRAIL_96}, {KIND_DATA, TRAIL_BC}, {KIND_DATA, TRAIL_9C},
            {KIND_DATA, TRAIL_87}, {KIND_DATA, TRAIL_A7}, {KIND_DATA, LEAD_C4},
            {KIND_DATA, TRAIL_9E}, {KIND_DATA, TRAIL_9E}, {KIND_DATA, LEAD_C5},
            {KIND_DATA, TRAIL_9F}, {KIND_DATA, LEAD_C4},  {KIND_COMMAND, 8'h01},
            {KIND_DATA, TRAIL_B1}, {KIND_DATA, LEAD_C4},  {KIND_DATA, LEAD_C5},
            {KIND_DATA, TRAIL_9F}, {KIND_DATA, TRAIL_9E}, {KIND_DATA, LEAD_C4},
            {KIND_DATA, TRAIL_B0}
        };
        sb        = new();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = REG_BUS_EIGHT_BIT;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_byte(directed[i].kind, directed[i].value);
        wait_quiet(QUIET_CYCLES);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p > 0)
                apply_setting(p);
            target = sb.sent_bytes + BYTES_PER_PH;
            while (sb.sent_bytes < target)
                send_random_text();
            wait_quiet(QUIET_CYCLES);
        end

        if (sb.errors == 0)
            $display("char_lcd_utf8_bus_writer_top_tb: clean");
        else
            $display("char_lcd_utf8_bus_writer_top_tb: errors");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("char_lcd_utf8_bus_writer_top_tb: errors");
        $finish;
    end

endmodule

FILE: char_lcd_utf8_bus_writer_top.f
rtl/clbw_pkg.sv
rtl/clbw_filter.sv
rtl/clbw_queue.sv
rtl/clbw_phase.sv
rtl/char_lcd_utf8_bus_writer_top.sv
dv/char_lcd_utf8_bus_writer_top_tb.sv
